[sv/led_chain_pwm_bit_encoder_top_defines.svh]
// ----------------------------------------------------------------------------
// LED chain PWM bit encoder: assertion macros
// Shared concurrent assertion forms used by the encoder's modules.
// ----------------------------------------------------------------------------
`ifndef LED_CHAIN_PWM_BIT_ENCODER_TOP_DEFINES_SVH
`define LED_CHAIN_PWM_BIT_ENCODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCPWM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCPWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/lcpwm_pkg.sv]
// ----------------------------------------------------------------------------
// LED chain PWM bit encoder package
// Constants, register codes, the brightness table and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package lcpwm_pkg;

    // Chain length and latch gap length.
    localparam int LED_COUNT   = 12;
    localparam int RESET_SLOTS = 50;

    localparam int RESULT_LIMIT = 50;
    localparam int PIXEL_BITS   = 24;
    localparam int MAX_BRIGHT   = 45;

    localparam int LATCH_SLOTS = (RESET_SLOTS > RESULT_LIMIT) ? RESULT_LIMIT : RESET_SLOTS;
    localparam int RUN_MAX     = (LATCH_SLOTS > PIXEL_BITS) ? LATCH_SLOTS : PIXEL_BITS;
    localparam int CNT_W       = $clog2(RUN_MAX);
    localparam int BIT_W       = $clog2(PIXEL_BITS);

    localparam int COLOUR_W    = 8;
    localparam int DUTY_W      = 8;
    localparam int BRIGHT_W    = 6;
    localparam int PIX_IDX_W   = 4;
    localparam int TAN_W       = 17;
    localparam int PROD_W      = COLOUR_W + TAN_W;

    localparam int INDEX_TOP_I = (1 << PIX_IDX_W) - 1;
    localparam int POS_TOP_I   = (LED_COUNT - 1 > INDEX_TOP_I) ? INDEX_TOP_I : LED_COUNT - 1;
    localparam logic [PIX_IDX_W-1:0] POS_TOP = PIX_IDX_W'(POS_TOP_I);

    // Reset values of the configuration registers.
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = BRIGHT_W'(45);
    localparam logic [DUTY_W-1:0]   HIGH_RESET   = DUTY_W'(80);
    localparam logic [DUTY_W-1:0]   LOW_RESET    = DUTY_W'(40);

    // Command FIFO sizing.
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BRIGHTNESS = 2'd0,
        CFG_HIGH_DUTY  = 2'd1,
        CFG_LOW_DUTY   = 2'd2
    } cfg_idx_t;

    typedef enum logic [0:0] {
        FUNC_PIXEL = 1'b0,
        FUNC_LATCH = 1'b1
    } func_t;

    // One classified item on its way to the bit serialiser.
    typedef struct packed {
        logic                  is_latch;
        logic [PIXEL_BITS-1:0] word;
        logic [PIX_IDX_W-1:0]  pos;
    } cmd_t;

    // Duty codes used by the serialiser.
    typedef struct packed {
        logic [DUTY_W-1:0] high_duty;
        logic [DUTY_W-1:0] low_duty;
    } duty_cfg_t;

    // tan(b degrees) in Q1.16; angles above 45 degrees read as exactly one.
    function automatic logic [TAN_W-1:0] tan_q16(input logic [BRIGHT_W-1:0] b);
        logic [TAN_W-1:0] t;
        case (b)
            6'd0:    t = 17'd0;
            6'd1:    t = 17'd1144;
            6'd2:    t = 17'd2289;
            6'd3:    t = 17'd3435;
            6'd4:    t = 17'd4583;
            6'd5:    t = 17'd5734;
            6'd6:    t = 17'd6888;
            6'd7:    t = 17'd8047;
            6'd8:    t = 17'd9210;
            6'd9:    t = 17'd10380;
            6'd10:   t = 17'd11556;
            6'd11:   t = 17'd12739;
            6'd12:   t = 17'd13930;
            6'd13:   t = 17'd15130;
            6'd14:   t = 17'd16340;
            6'd15:   t = 17'd17560;
            6'd16:   t = 17'd18792;
            6'd17:   t = 17'd20036;
            6'd18:   t = 17'd21294;
            6'd19:   t = 17'd22566;
            6'd20:   t = 17'd23853;
            6'd21:   t = 17'd25157;
            6'd22:   t = 17'd26478;
            6'd23:   t = 17'd27818;
            6'd24:   t = 17'd29179;
            6'd25:   t = 17'd30560;
            6'd26:   t = 17'd31964;
            6'd27:   t = 17'd33392;
            6'd28:   t = 17'd34846;
            6'd29:   t = 17'd36327;
            6'd30:   t = 17'd37837;
            6'd31:   t = 17'd39378;
            6'd32:   t = 17'd40951;
            6'd33:   t = 17'd42560;
            6'd34:   t = 17'd44205;
            6'd35:   t = 17'd45889;
            6'd36:   t = 17'd47615;
            6'd37:   t = 17'd49385;
            6'd38:   t = 17'd51202;
            6'd39:   t = 17'd53070;
            6'd40:   t = 17'd54991;
            6'd41:   t = 17'd56970;
            6'd42:   t = 17'd59009;
            6'd43:   t = 17'd61113;
            6'd44:   t = 17'd63287;
            default: t = 17'd65536;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

[sv/lcpwm_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// LED chain PWM bit encoder: command FIFO
// Short register FIFO between the classifying front end and the serialiser.
// ----------------------------------------------------------------------------
`default_nettype none
`include "led_chain_pwm_bit_encoder_top_defines.svh"

module lcpwm_cmd_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  lcpwm_pkg::cmd_t    wr_data,
    output logic               full,
    input  wire logic          pop,
    output lcpwm_pkg::cmd_t    rd_data,
    output logic               empty
);
    import lcpwm_pkg::*;

    cmd_t              mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == FCNT_W'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `LCPWM_ASSERT_SAME(a_no_overflow, clk, rst_n, push, !full, "command FIFO written while full")
    `LCPWM_ASSERT_SAME(a_count_range, clk, rst_n, 1'b1, count_reg <= FCNT_W'(FIFO_DEPTH), "command FIFO count out of range")

endmodule

`default_nettype wire

[sv/lcpwm_front.sv]
// ----------------------------------------------------------------------------
// LED chain PWM bit encoder: front end
// Classifies each item, scales the colours and tracks the chain position.
// ----------------------------------------------------------------------------
`default_nettype none
`include "led_chain_pwm_bit_encoder_top_defines.svh"

module lcpwm_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            fire,
    input  wire logic                            func,
    input  wire logic [lcpwm_pkg::COLOUR_W-1:0]  red,
    input  wire logic [lcpwm_pkg::COLOUR_W-1:0]  green,
    input  wire logic [lcpwm_pkg::COLOUR_W-1:0]  blue,
    input  wire logic [lcpwm_pkg::BRIGHT_W-1:0]  brightness,
    output lcpwm_pkg::cmd_t                      cmd
);
    import lcpwm_pkg::*;

    logic [PIX_IDX_W-1:0] pos_reg, pos_next;
    logic [TAN_W-1:0]     scale;
    logic [PROD_W-1:0]    prod_r, prod_g, prod_b;
    logic                 is_latch;

    // Brightness values above the table's last angle read as unity gain.
    assign scale    = tan_q16(brightness);
    assign is_latch = (func == FUNC_LATCH);

    always_comb
    begin
        prod_r = PROD_W'(red)   * PROD_W'(scale);
        prod_g = PROD_W'(green) * PROD_W'(scale);
        prod_b = PROD_W'(blue)  * PROD_W'(scale);

        cmd.is_latch = is_latch;
        cmd.word     = {prod_g[23:16], prod_r[23:16], prod_b[23:16]};
        cmd.pos      = is_latch ? '0 : pos_reg;

        pos_next = pos_reg;
        if (fire)
        begin
            if (is_latch)
            begin
                pos_next = '0;
            end
            else if (pos_reg < POS_TOP)
            begin
                pos_next = pos_reg + 1'b1;
            end
            else
            begin
                pos_next = POS_TOP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    `LCPWM_ASSERT_SAME(a_pos_range, clk, rst_n, 1'b1, pos_reg <= POS_TOP, "chain position beyond last LED")

endmodule

`default_nettype wire

[sv/lcpwm_back.sv]
// ----------------------------------------------------------------------------
// LED chain PWM bit encoder: bit serialiser
// Turns queued commands into runs of duty codes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "led_chain_pwm_bit_encoder_top_defines.svh"

module lcpwm_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  lcpwm_pkg::cmd_t                       cmd,
    input  wire logic                             cmd_empty,
    output logic                                  cmd_pop,
    input  lcpwm_pkg::duty_cfg_t                  duty_cfg,
    output logic                                  out_valid,
    input  wire logic                             out_pop,
    output logic [lcpwm_pkg::DUTY_W-1:0]          duty,
    output logic [lcpwm_pkg::PIX_IDX_W-1:0]       pixel_index,
    output logic                                  last
);
    import lcpwm_pkg::*;

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0]    out_duty_reg;
    logic [PIX_IDX_W-1:0] out_idx_reg;
    logic                 out_last_reg;

    logic [BIT_W-1:0]     bit_idx;
    logic                 load_ok;
    logic                 emit;
    logic                 run_last;
    logic [DUTY_W-1:0]    duty_sel;

    always_comb
    begin
        bit_idx  = BIT_W'(PIXEL_BITS - 1) - cnt_reg[BIT_W-1:0];
        load_ok  = !out_valid_reg || out_pop;
        emit     = !cmd_empty && load_ok;
        run_last = cmd.is_latch ? (cnt_reg == CNT_W'(LATCH_SLOTS - 1))
                                : (cnt_reg == CNT_W'(PIXEL_BITS - 1));
        cmd_pop  = emit && run_last;

        if (cmd.is_latch)
        begin
            duty_sel = '0;
        end
        else if (cmd.word[bit_idx])
        begin
            duty_sel = duty_cfg.high_duty;
        end
        else
        begin
            duty_sel = duty_cfg.low_duty;
        end

        cnt_next = cnt_reg;
        if (emit)
        begin
            cnt_next = run_last ? '0 : cnt_reg + 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_duty_reg <= duty_sel;
            out_idx_reg  <= cmd.pos;
            out_last_reg <= run_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign duty        = out_duty_reg;
    assign pixel_index = out_idx_reg;
    assign last        = out_last_reg;

    `LCPWM_ASSERT_SAME(a_pop_nonempty, clk, rst_n, cmd_pop, !cmd_empty, "command retired from an empty FIFO")
    `LCPWM_ASSERT_NEXT(a_pop_marks_last, clk, rst_n, cmd_pop, out_valid_reg && out_last_reg, "retired command did not end its run")
    `LCPWM_ASSERT_SAME(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(RUN_MAX - 1), "slot counter past longest run")

endmodule

`default_nettype wire

[sv/led_chain_pwm_bit_encoder_top.sv]
// With the serialiser idle, an accepted item is written into the command FIFO and then
// loaded into the result register, which drives the first result beat onto the outputs.
// Throughput: one duty beat per cycle while the result register is empty or being read;
// a pixel is a run of 24 bit slots, a latch gap 50, emitted by the serialiser from the FIFO.
// One further item is taken while a run is still being serialised.
// Reset (rst_n low, asynchronous): queues empty, chain position 0, registers to defaults.
// ----------------------------------------------------------------------------
// LED chain PWM bit encoder: top level
// Scales GRB pixels and sends one timer duty code per bit, plus latch gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module led_chain_pwm_bit_encoder_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    // Item side, presented as a queue being written.
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic                              func,
    input  wire logic [lcpwm_pkg::COLOUR_W-1:0]    red,
    input  wire logic [lcpwm_pkg::COLOUR_W-1:0]    green,
    input  wire logic [lcpwm_pkg::COLOUR_W-1:0]    blue,

    // Result side, presented as a queue being read.
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [lcpwm_pkg::DUTY_W-1:0]           duty,
    output logic [lcpwm_pkg::PIX_IDX_W-1:0]        pixel_index,
    output logic                                   last,

    // Configuration write port.
    input  wire logic                              cfg_we,
    input  wire logic [lcpwm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lcpwm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lcpwm_pkg::*;

    // Configuration registers. Writes to an index beyond the list are dropped.
    logic [BRIGHT_W-1:0] brightness_reg, brightness_next;
    logic [DUTY_W-1:0]   high_duty_reg, high_duty_next;
    logic [DUTY_W-1:0]   low_duty_reg, low_duty_next;

    logic      fire;
    cmd_t      front_cmd;
    cmd_t      fifo_cmd;
    logic      fifo_full;
    logic      fifo_empty;
    logic      fifo_pop;
    logic      out_valid;
    duty_cfg_t duty_cfg;

    always_comb
    begin
        brightness_next = brightness_reg;
        high_duty_next  = high_duty_reg;
        low_duty_next   = low_duty_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BRIGHTNESS: brightness_next = cfg_data[BRIGHT_W-1:0];
                CFG_HIGH_DUTY:  high_duty_next  = cfg_data[DUTY_W-1:0];
                CFG_LOW_DUTY:   low_duty_next   = cfg_data[DUTY_W-1:0];
                default:        brightness_next = brightness_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= BRIGHT_RESET;
            high_duty_reg  <= HIGH_RESET;
            low_duty_reg   <= LOW_RESET;
        end
        else
        begin
            brightness_reg <= brightness_next;
            high_duty_reg  <= high_duty_next;
            low_duty_reg   <= low_duty_next;
        end
    end

    // An item beat is taken whenever the command FIFO has room, so the front
    // end keeps accepting while the serialiser and the result register are busy.
    assign full  = fifo_full;
    assign fire  = push && !fifo_full;

    assign duty_cfg.high_duty = high_duty_reg;
    assign duty_cfg.low_duty  = low_duty_reg;

    // The front end scales the colours and packs them into the GRB word in the
    // same cycle as acceptance; the packed command lands in the FIFO.
    lcpwm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .func       (func),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .brightness (brightness_reg),
        .cmd        (front_cmd)
    );

    lcpwm_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fire),
        .wr_data (front_cmd),
        .full    (fifo_full),
        .pop     (fifo_pop),
        .rd_data (fifo_cmd),
        .empty   (fifo_empty)
    );

    // The serialiser walks the head command slot by slot into a single result register,
    // which advances whenever a command is queued and the register is empty or being read.
    lcpwm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (fifo_cmd),
        .cmd_empty   (fifo_empty),
        .cmd_pop     (fifo_pop),
        .duty_cfg    (duty_cfg),
        .out_valid   (out_valid),
        .out_pop     (pop),
        .duty        (duty),
        .pixel_index (pixel_index),
        .last        (last)
    );

    assign empty = !out_valid;

endmodule

`default_nettype wire
